// ===== rtl/core/tlf_pkg.sv =====
// Shared types, constants and codes for the text line folder.
package tlf_pkg;

	localparam int BUF_DEPTH = 62;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int COL_W     = 7;
	localparam int FW_W      = 6;
	localparam int CFG_IDX_W = 2;
	localparam int TAB_STOP  = 8;

	localparam logic [COL_W-1:0] COL_MAX        = 7'd127;
	localparam logic [FW_W-1:0]  FOLD_WIDTH_RST = 6'd61;
	localparam logic [COL_W:0]   TAB_INC        = (COL_W + 1)'(TAB_STOP);
	localparam logic [COL_W:0]   TAB_MASK       = ~((COL_W + 1)'(TAB_STOP - 1));

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOLD_WIDTH     = 2'd0,
		CFG_SPLIT_AT_SPACE = 2'd1,
		CFG_COUNT_BYTES    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_EMIT,
		ST_PUSH,
		ST_MOVE,
		ST_REBASE,
		ST_APPEND
	} state_t;

	typedef enum logic {
		ALU_ADV,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [FW_W-1:0] fold_width;
		logic            split_at_space;
		logic            count_bytes;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       ch;
		logic [COL_W-1:0] col;
	} entry_t;

	typedef struct packed {
		alu_op_t          op;
		logic [COL_W-1:0] a;
		logic [COL_W-1:0] sub_val;
		logic [7:0]       ch;
		logic             count_bytes;
	} alu_req_t;

	typedef struct packed {
		logic             wr_en;
		logic [CNT_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             rd_en;
		logic [CNT_W-1:0] rd_addr;
	} buf_req_t;

endpackage

// ===== rtl/core/tlf_col_alu.sv =====
// Shared column unit: advance a column past a byte, or rebase a column.
module tlf_col_alu (
	input  tlf_pkg::alu_req_t          req,
	output logic [tlf_pkg::COL_W-1:0]  res
);
	import tlf_pkg::*;

	logic [COL_W:0] wide;

	always_comb begin
		wide = '0;
		res  = '0;
		unique case (req.op)
			ALU_SUB: begin
				res = (req.a > req.sub_val) ? (req.a - req.sub_val) : '0;
			end
			ALU_ADV: begin
				if (req.ch == CH_TAB && !req.count_bytes) begin
					wide = ({1'b0, req.a} + TAB_INC) & TAB_MASK;
				end else if (req.ch == CH_BS && !req.count_bytes) begin
					wide = (req.a != '0) ? ({1'b0, req.a} - (COL_W + 1)'(1)) : '0;
				end else begin
					wide = {1'b0, req.a} + (COL_W + 1)'(1);
				end
				// saturate on the way up
				res = (wide > {1'b0, COL_MAX}) ? COL_MAX : wide[COL_W-1:0];
			end
			default: res = '0;
		endcase
	end

endmodule

// ===== rtl/core/tlf_buf.sv =====
// Pending byte buffer: one write and one registered read port.
module tlf_buf (
	input  logic              clk,
	input  tlf_pkg::buf_req_t req,
	output tlf_pkg::entry_t   rd_data
);
	import tlf_pkg::*;

	entry_t mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr[IDX_W-1:0]];
		end
	end

endmodule

// ===== rtl/core/tlf_seq.sv =====
// Sequencer: decides break or append, streams the buffer out, compacts it.
module tlf_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlf_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        end_of_input,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        last,
	output logic                        overflow,
	output tlf_pkg::buf_req_t           buf_req,
	input  tlf_pkg::entry_t             buf_rd,
	output tlf_pkg::alu_req_t           alu_req,
	input  logic [tlf_pkg::COL_W-1:0]   alu_res
);
	import tlf_pkg::*;

	state_t           state_q, state_d;
	logic [7:0]       byte_q;
	logic             eoi_q;
	logic [CNT_W-1:0] cnt_q;
	logic [COL_W-1:0] cur_q;
	logic             spc_vld_q;
	logic [CNT_W-1:0] spc_idx_q;
	logic [COL_W-1:0] spc_col_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] mv_end_q;
	logic [COL_W-1:0] base_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] widx_q;
	logic             rvld_q;
	logic             brk_q;
	logic             mv_q;
	logic             push_ovf_q;
	logic [7:0]       push_byte_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             ovf_q;

	logic             out_free;
	logic             is_le;
	logic             brk;
	logic             full;
	logic             mv;
	logic [CNT_W-1:0] k_sp;
	logic             emit_done;
	logic             emit_load;
	logic             push_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign is_le     = (byte_q == CH_LF) || (byte_q == CH_CR);
	assign brk       = alu_res > COL_W'(cfg.fold_width);
	assign full      = cnt_q == CNT_W'(BUF_DEPTH);
	assign k_sp      = spc_idx_q + CNT_W'(1);
	// break after the last space only when the new byte is no space and bytes remain behind it
	assign mv        = cfg.split_at_space && (byte_q != CH_SP) && spc_vld_q && (k_sp != cnt_q);
	assign emit_done = (idx_q == k_q) && (!rvld_q || out_free);

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign overflow  = ovf_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				priority if (eoi_q) begin
					state_d = (cnt_q == '0) ? ST_IDLE : ST_EMIT;
				end else if (is_le || brk) begin
					state_d = ST_EMIT;
				end else if (full) begin
					state_d = ST_PUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT:   if (emit_done) state_d = eoi_q ? ST_IDLE : ST_PUSH;
			ST_PUSH: begin
				if (out_free) begin
					state_d = !brk_q ? ST_IDLE : (mv_q ? ST_MOVE : ST_APPEND);
				end
			end
			ST_MOVE:   if (idx_q == mv_end_q) state_d = ST_REBASE;
			ST_REBASE: state_d = ST_APPEND;
			ST_APPEND: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		alu_req.op          = ALU_ADV;
		alu_req.a           = cur_q;
		alu_req.sub_val     = base_q;
		alu_req.ch          = byte_q;
		alu_req.count_bytes = cfg.count_bytes;
		buf_req.wr_en       = 1'b0;
		buf_req.wr_addr     = cnt_q;
		buf_req.wr_data     = '{ch: byte_q, col: alu_res};
		buf_req.rd_en       = 1'b0;
		buf_req.rd_addr     = idx_q;
		emit_load           = 1'b0;
		push_load           = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_DECIDE: begin
				buf_req.wr_en = !eoi_q && !is_le && !brk && !full;
			end
			ST_EMIT: begin
				buf_req.rd_en = (idx_q < k_q) && (!rvld_q || out_free);
				emit_load     = rvld_q && out_free;
			end
			ST_PUSH: begin
				push_load = out_free;
			end
			ST_MOVE: begin
				alu_req.op      = ALU_SUB;
				alu_req.a       = buf_rd.col;
				buf_req.rd_en   = idx_q < mv_end_q;
				buf_req.wr_en   = rvld_q;
				buf_req.wr_addr = widx_q;
				buf_req.wr_data = '{ch: buf_rd.ch, col: alu_res};
			end
			ST_REBASE: begin
				alu_req.op = ALU_SUB;
			end
			ST_APPEND: begin
				buf_req.wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_q      <= '0;
			eoi_q       <= 1'b0;
			cnt_q       <= '0;
			cur_q       <= '0;
			spc_vld_q   <= 1'b0;
			spc_idx_q   <= '0;
			spc_col_q   <= '0;
			k_q         <= '0;
			mv_end_q    <= '0;
			base_q      <= '0;
			idx_q       <= '0;
			widx_q      <= '0;
			rvld_q      <= 1'b0;
			brk_q       <= 1'b0;
			mv_q        <= 1'b0;
			push_ovf_q  <= 1'b0;
			push_byte_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (emit_load || push_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						byte_q <= in_byte;
						eoi_q  <= end_of_input;
					end
				end
				ST_DECIDE: begin
					idx_q  <= '0;
					widx_q <= '0;
					rvld_q <= 1'b0;
					priority if (eoi_q || is_le) begin
						k_q         <= cnt_q;
						cnt_q       <= '0;
						cur_q       <= '0;
						spc_vld_q   <= 1'b0;
						brk_q       <= 1'b0;
						mv_q        <= 1'b0;
						push_ovf_q  <= 1'b0;
						push_byte_q <= byte_q;
					end else if (brk) begin
						brk_q       <= 1'b1;
						mv_q        <= mv;
						push_ovf_q  <= 1'b0;
						push_byte_q <= CH_LF;
						spc_vld_q   <= 1'b0;
						if (mv) begin
							k_q      <= k_sp;
							mv_end_q <= cnt_q;
							cnt_q    <= cnt_q - k_sp;
							base_q   <= spc_col_q;
						end else begin
							k_q   <= cnt_q;
							cnt_q <= '0;
							cur_q <= '0;
						end
					end else if (full) begin
						// drop the byte and report it
						brk_q       <= 1'b0;
						mv_q        <= 1'b0;
						push_ovf_q  <= 1'b1;
						push_byte_q <= '0;
					end else begin
						brk_q       <= 1'b0;
						mv_q        <= 1'b0;
						push_ovf_q  <= 1'b0;
						push_byte_q <= byte_q;
						cnt_q       <= cnt_q + CNT_W'(1);
						cur_q       <= alu_res;
						if (byte_q == CH_SP && cnt_q != '0) begin
							spc_vld_q <= 1'b1;
							spc_idx_q <= cnt_q;
							spc_col_q <= alu_res;
						end
					end
				end
				ST_EMIT: begin
					if (buf_req.rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					rvld_q <= buf_req.rd_en || (rvld_q && !out_free);
				end
				ST_PUSH: ;
				ST_MOVE: begin
					if (buf_req.rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					rvld_q <= buf_req.rd_en;
					if (rvld_q) begin
						widx_q <= widx_q + CNT_W'(1);
					end
				end
				ST_REBASE: begin
					cur_q <= alu_res;
				end
				ST_APPEND: begin
					cnt_q <= cnt_q + CNT_W'(1);
					cur_q <= alu_res;
					if (byte_q == CH_SP && cnt_q != '0) begin
						spc_vld_q <= 1'b1;
						spc_idx_q <= cnt_q;
						spc_col_q <= alu_res;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_byte_q <= buf_rd.ch;
			last_q     <= eoi_q && (idx_q == k_q);
			ovf_q      <= 1'b0;
		end else if (push_load) begin
			out_byte_q <= push_byte_q;
			last_q     <= 1'b1;
			ovf_q      <= push_ovf_q;
		end
	end

endmodule

// ===== rtl/core/text_line_folder_top.sv =====
// Top level of the text line folder: configuration registers and core wiring.
//
//  channel  | handshake            | words
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | in_byte, end_of_input
//  output   | out_valid / out_stall| out_byte, last, overflow
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A byte that is only buffered is accepted, then decided and written. A flush
// decides, emits the buffered words through the single buffer read port and,
// unless at end of input, pushes a final word; a dropped byte is decided and
// then pushed. A break adds an append of the byte, and a break after a space
// first moves the bytes after it to the buffer front, then rebases the column.
// Output stalls hold the sequencer; the buffer needs no clearing after reset.
module text_line_folder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tlf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlf_pkg::FW_W-1:0]         cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       in_byte,
	input  logic                             end_of_input,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic                             last,
	output logic                             overflow
);
	import tlf_pkg::*;

	cfg_t             cfg_q;
	buf_req_t         buf_req;
	entry_t           buf_rd;
	alu_req_t         alu_req;
	logic [COL_W-1:0] alu_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fold_width     <= FOLD_WIDTH_RST;
			cfg_q.split_at_space <= 1'b0;
			cfg_q.count_bytes    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FOLD_WIDTH:     cfg_q.fold_width     <= cfg_data;
				CFG_SPLIT_AT_SPACE: cfg_q.split_at_space <= cfg_data[0];
				CFG_COUNT_BYTES:    cfg_q.count_bytes    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tlf_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last         (last),
		.overflow     (overflow),
		.buf_req      (buf_req),
		.buf_rd       (buf_rd),
		.alu_req      (alu_req),
		.alu_res      (alu_res)
	);

	tlf_buf u_buf (
		.clk     (clk),
		.req     (buf_req),
		.rd_data (buf_rd)
	);

	tlf_col_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

endmodule

// ===== rtl/core/tlf_checker.sv =====
// Port-level checks for the text line folder, bound to the top level.
module tlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last,
	input logic       overflow
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last)
			&& $stable(overflow))
		else $error("output word changed under stall");

	// a dropped byte is reported by one final zero word
	a_ovf_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> last && (out_byte == 8'h00))
		else $error("overflow word malformed");

	// an accepted item keeps the block busy in the following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken back to back");

	// while a non-final word of an item waits, no new item is taken
	a_item_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open before item finished");

endmodule

bind text_line_folder_top tlf_checker u_tlf_checker (.*);

// ===== test/text_line_folder_top_tb.sv =====
// Self-checking testbench for the text line folder: random text, random stalls, scoreboard.
module text_line_folder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlf_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       eoi;
		int         gap;
	} text_item_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       ovf;
	} fold_word_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [FW_W-1:0]      cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [7:0]           in_byte      = 8'h00;
	logic                 end_of_input = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [7:0]           out_byte;
	logic                 last;
	logic                 overflow;

	text_line_folder_top u_dut (.*);

	always #5ns clk = ~clk;

	// folder state as predicted from the accepted bytes
	logic [FW_W-1:0] fold_width_q = FOLD_WIDTH_RST;
	logic            split_q      = 1'b0;
	logic            count_q      = 1'b0;
	logic [7:0]      line_bytes[BUF_DEPTH];
	int              line_cols[BUF_DEPTH + 1];
	int              line_len     = 0;
	int              line_col     = 0;

	text_item_t text_q[$];
	fold_word_t folded_words[$];
	text_item_t next_item;
	fold_word_t want;
	int         text_pushed    = 0;
	int         mismatch_count = 0;
	int         tx_mode        = 2;
	int         rx_mode        = 2;
	int         rx_wait        = 0;
	int         hold_req       = 0;
	int         hold_left      = 0;

	for (genvar gi = 0; gi <= BUF_DEPTH; gi++) begin : g_col_init
		initial line_cols[gi] = 0;
	end

	task automatic report_mismatch(string what);
		if (mismatch_count < 100)
			$display("%0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int draw_idle(int mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
			default: return $urandom_range(0, 17);
		endcase
	endfunction

	function automatic int col_sat(int c);
		return (c > COL_MAX) ? COL_MAX : c;
	endfunction

	function automatic int col_sub(int a, int b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic int col_step(int c, logic [7:0] b);
		if (b == CH_TAB)
			return col_sat(count_q ? c + 1 : ((c + TAB_STOP) / TAB_STOP) * TAB_STOP);
		if (b == CH_BS)
			return count_q ? col_sat(c + 1) : ((c > 0) ? c - 1 : 0);
		return col_sat(c + 1);
	endfunction

	function automatic void flush_line(ref fold_word_t res[$]);
		for (int i = 0; i < line_len; i++)
			res.push_back('{line_bytes[i], 1'b0, 1'b0});
		line_len     = 0;
		line_col     = 0;
		line_cols[0] = 0;
	endfunction

	// work out the words one accepted byte causes and queue them
	function automatic void fold_predict(logic [7:0] b, logic eoi);
		fold_word_t res[$];
		int         k;
		int         j;
		int         base;
		if (eoi) begin
			flush_line(res);
		end else if (b == CH_LF || b == CH_CR) begin
			flush_line(res);
			res.push_back('{b, 1'b0, 1'b0});
		end else begin
			if (col_step(line_col, b) > fold_width_q) begin
				if (split_q) begin
					if (line_len == 0) begin
						k = 0;
					end else begin
						j = line_len - 1;
						if (b != CH_SP) begin
							while (j > 0 && line_bytes[j] != CH_SP)
								j--;
							if (j == 0)
								j = line_len - 1;
						end
						k = j + 1;
					end
					for (int i = 0; i < k; i++)
						res.push_back('{line_bytes[i], 1'b0, 1'b0});
					// move the tail to the front and rebase its columns
					base = line_cols[k];
					for (int i = k; i < line_len; i++)
						line_bytes[i - k] = line_bytes[i];
					for (int i = k; i <= line_len; i++)
						line_cols[i - k] = col_sub(line_cols[i], base);
					line_col = col_sub(line_col, base);
					line_len = line_len - k;
				end else begin
					flush_line(res);
				end
				res.push_back('{CH_LF, 1'b0, 1'b0});
			end
			if (line_len >= BUF_DEPTH) begin
				res.push_back('{8'h00, 1'b0, 1'b1});
			end else begin
				line_bytes[line_len] = b;
				line_len++;
				line_col = col_step(line_col, b);
				line_cols[line_len] = line_col;
			end
		end
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
		foreach (res[i])
			folded_words.push_back(res[i]);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			in_byte      <= 8'h00;
			end_of_input <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				fold_predict(in_byte, end_of_input);
			if (!in_valid || !in_stall) begin
				if (text_q.size() > 0 && text_q[0].gap > 0) begin
					text_q[0].gap = text_q[0].gap - 1;
					in_valid <= 1'b0;
				end else if (text_q.size() > 0) begin
					next_item = text_q.pop_front();
					in_byte      <= next_item.data;
					end_of_input <= next_item.eoi;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (folded_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h last %b overflow %b",
						out_byte, last, overflow));
				end else begin
					want = folded_words.pop_front();
					if (out_byte !== want.data)
						report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.data));
					if (last !== want.last)
						report_mismatch($sformatf("last %b, want %b on word %h",
							last, want.last, want.data));
					if (overflow !== want.ovf)
						report_mismatch($sformatf("overflow %b, want %b on word %h",
							overflow, want.ovf, want.data));
				end
				rx_wait = draw_idle(rx_mode);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic add_text(logic [7:0] b, logic eoi);
		text_q.push_back('{b, eoi, draw_idle(tx_mode)});
		text_pushed++;
	endtask

	task automatic add_word(int len);
		for (int i = 0; i < len; i++)
			add_text(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h61, 8'h7a))
				: 8'($urandom_range(8'h21, 8'h7e)), 1'b0);
	endtask

	// mostly words and lines, with backspace runs, end-of-input marks, long lines and noise
	task automatic add_random_text(int n);
		int stop_at;
		int sel;
		stop_at = text_pushed + n;
		while (text_pushed < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				add_word($urandom_range(1, 12));
				add_text(($urandom_range(0, 5) == 0) ? CH_TAB : CH_SP, 1'b0);
			end else if (sel < 64) begin
				add_text(($urandom_range(0, 2) == 0) ? CH_CR : CH_LF, 1'b0);
			end else if (sel < 70) begin
				// printable byte plus backspace keeps the column low unless bytes are counted, and fills the buffer
				repeat ($urandom_range(15, 36)) begin
					add_word(1);
					add_text(CH_BS, 1'b0);
				end
			end else if (sel < 78) begin
				add_text(8'($urandom_range(0, 255)), 1'b1);
			end else if (sel < 84) begin
				add_word($urandom_range(20, 70));
			end else begin
				add_text(8'($urandom_range(0, 255)), 1'b0);
			end
		end
	endtask

	// returns once every byte is taken, every word has come and the core is idle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (text_q.size() > 0 || in_valid || folded_words.size() > 0 || in_stall);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [FW_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_FOLD_WIDTH:     fold_width_q = val;
			CFG_SPLIT_AT_SPACE: split_q      = val[0];
			CFG_COUNT_BYTES:    count_q      = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [FW_W-1:0] fw, logic split, logic cntb);
		write_reg(CFG_FOLD_WIDTH, fw);
		write_reg(CFG_SPLIT_AT_SPACE, {5'($urandom_range(0, 31)), split});
		write_reg(CFG_COUNT_BYTES, {5'($urandom_range(0, 31)), cntb});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [FW_W-1:0] fw, logic split, logic cntb, int n,
			int tx, int rx, int hold);
		set_config(fw, split, cntb);
		tx_mode = tx;
		rx_mode = rx;
		if (hold > 0)
			hold_req = hold;
		add_random_text(n);
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty end of input, backspace at column 0, byte extremes, line ends
		tx_mode = 1;
		rx_mode = 1;
		add_text(8'hFF, 1'b1);
		add_text(CH_BS, 1'b0);
		add_text(8'h00, 1'b0);
		add_text(8'hFF, 1'b0);
		add_text(CH_TAB, 1'b0);
		add_text(CH_BS, 1'b0);
		add_text(CH_SP, 1'b0);
		add_text(CH_CR, 1'b0);
		add_text(8'h78, 1'b0);
		add_text(CH_LF, 1'b0);
		add_text(8'h79, 1'b0);
		add_text(CH_LF, 1'b1);
		wait_drained();

		// zero width: break with empty buffer, space split of single bytes, byte counting
		set_config(6'd0, 1'b1, 1'b1);
		add_text(8'h61, 1'b0);
		add_text(8'h62, 1'b0);
		add_text(CH_SP, 1'b0);
		add_text(CH_TAB, 1'b0);
		add_text(CH_BS, 1'b0);
		add_text(CH_LF, 1'b0);
		add_text(8'h00, 1'b1);
		wait_drained();

		run_phase(6'd61, 1'b0, 1'b0, 50, 2, 2, 0);
		// long output hold while bytes keep coming
		run_phase(6'd1, 1'b1, 1'b0, 40, 0, 1, 400);
		run_phase(6'd0, 1'b0, 1'b1, 30, 1, 0, 0);
		run_phase(6'd63, 1'b1, 1'b1, 50, 2, 0, 0);
		run_phase(6'd62, 1'b0, 1'b0, 50, 0, 2, 0);
		run_phase(6'd8, 1'b1, 1'b0, 50, 1, 1, 0);
		run_phase(6'd20, 1'b0, 1'b1, 40, 0, 0, 0);
		repeat (4)
			run_phase(6'($urandom_range(0, 63)), 1'($urandom), 1'($urandom), 35,
				$urandom_range(0, 2), $urandom_range(0, 2), 0);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
